>>> rtl/sha512_pkg.sv
// Shared constants and types for the SHA-512 stream hasher.
package sha512_pkg;

    // Words per 1024-bit block, rounds per block and digest length in words.
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUND_COUNT  = 80;
    localparam int DIGEST_WORDS = 8;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    // Initial hash value.
    localparam logic [63:0] INIT_HASH [DIGEST_WORDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // Round constants.
    localparam logic [63:0] ROUND_CONST [ROUND_COUNT] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    // Padding start marker: the 0x80 byte in the top byte of a word.
    localparam logic [63:0] PAD_MARKER = 64'h8000_0000_0000_0000;

    // Largest byte count a message word can carry.
    localparam logic [3:0] FULL_BYTES = 4'd8;

endpackage

>>> rtl/sha512_stream_hasher.sv
// SHA-512 stream hasher: block buffer, padding sequencer, round unit and digest output.
//
// The message enters on the request channel message_valid / message_stall as big-endian
// 64-bit words (first byte in bits 63..56). A word with end_of_message set closes the
// message; valid_bytes then gives its leading valid bytes (values above 8 count as 8).
// After the closing word the block sends eight digest requests on digest_valid /
// digest_stall, most significant word first, with digest_index and digest_last.
// One round unit does a single SHA-512 round per cycle; a 16-word block runs through
// all its rounds and the result is then folded into the chaining value.
// An ordinary word is taken whenever the block is idle; the word that fills a block stalls
// the input until its rounds and fold are done, so no new word enters during a compression.
// The closing word is followed by 2 to 18 padding words, one or two compressions
// and the loading of the eight digest words into the output register.
// The input is stalled during padding, rounds, the fold and digest output; it reopens as
// soon as the last digest word sits in the output register.
// A stalled digest request holds its word; the sequencer waits until it is taken.
// Reset loads the initial hash value and clears the message length in bits and block fill.
module sha512_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        message_valid,
    output logic        message_stall,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [63:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_last
);

    localparam int RoundBits = $clog2(sha512_pkg::ROUND_COUNT);
    localparam int FillBits  = $clog2(sha512_pkg::BLOCK_WORDS);
    localparam int IdxBits   = $clog2(sha512_pkg::DIGEST_WORDS);
    localparam logic [RoundBits-1:0] LastRound = RoundBits'(sha512_pkg::ROUND_COUNT - 1);
    localparam logic [FillBits-1:0]  LenSlot   = FillBits'(sha512_pkg::BLOCK_WORDS - 1);
    localparam logic [FillBits-1:0]  ZeroSlot  = FillBits'(sha512_pkg::BLOCK_WORDS - 2);
    localparam logic [IdxBits-1:0]   LastIdx   = IdxBits'(sha512_pkg::DIGEST_WORDS - 1);

    // Control state.
    sha512_pkg::state_t state_reg, state_next;
    logic [FillBits-1:0]  fill_reg, fill_next;
    logic [RoundBits-1:0] round_reg, round_next;
    logic [IdxBits-1:0]   idx_reg, idx_next;
    logic [63:0]          len_reg, len_next;
    logic                 pad_reg, pad_next;
    logic                 pend80_reg, pend80_next;
    logic                 seen14_reg, seen14_next;
    logic                 done_reg, done_next;
    logic                 dvalid_reg, dvalid_next;
    logic [63:0]          chain_reg [sha512_pkg::DIGEST_WORDS];
    logic [63:0]          chain_next [sha512_pkg::DIGEST_WORDS];

    // Datapath state.
    logic [63:0] win_reg [sha512_pkg::BLOCK_WORDS];
    logic [63:0] win_next [sha512_pkg::BLOCK_WORDS];
    logic [63:0] var_reg [8];
    logic [63:0] var_next [8];
    logic [63:0] dword_reg, dword_next;
    logic [IdxBits-1:0] dindex_reg, dindex_next;
    logic        dlast_reg, dlast_next;

    // Round unit signals.
    logic        accept;
    logic        push_en;
    logic [63:0] push_word;
    logic        shift_en;
    logic [63:0] shift_in;
    logic [3:0]  nb_clamp;
    logic [5:0]  nb_shift;
    logic [63:0] keep_mask;
    logic [63:0] last_word;
    logic [63:0] sched_new;
    logic [63:0] t1, t2;
    logic        out_free;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned s);
        rotr = (x >> s) | (x << (64 - s));
    endfunction

    assign accept   = message_valid && !message_stall;
    assign out_free = !dvalid_reg || !digest_stall;

    // Closing word: clamp the byte count, keep the valid bytes and append the marker byte.
    assign nb_clamp  = (valid_bytes > sha512_pkg::FULL_BYTES) ? sha512_pkg::FULL_BYTES
                                                             : valid_bytes;
    assign nb_shift  = {nb_clamp[2:0], 3'b000};
    assign keep_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> nb_shift);
    assign last_word = (message_word & keep_mask) | (sha512_pkg::PAD_MARKER >> nb_shift);

    // Message schedule: next word from the fixed taps of the shifting window.
    assign sched_new = (rotr(win_reg[14], 19) ^ rotr(win_reg[14], 61) ^ (win_reg[14] >> 6))
                     + win_reg[9]
                     + (rotr(win_reg[1], 1) ^ rotr(win_reg[1], 8) ^ (win_reg[1] >> 7))
                     + win_reg[0];

    // One compression round.
    assign t1 = var_reg[7]
              + (rotr(var_reg[4], 14) ^ rotr(var_reg[4], 18) ^ rotr(var_reg[4], 41))
              + ((var_reg[4] & var_reg[5]) | (~var_reg[4] & var_reg[6]))
              + sha512_pkg::ROUND_CONST[round_reg]
              + win_reg[0];
    assign t2 = (rotr(var_reg[0], 28) ^ rotr(var_reg[0], 34) ^ rotr(var_reg[0], 39))
              + ((var_reg[0] & var_reg[1]) | (var_reg[0] & var_reg[2])
                 | (var_reg[1] & var_reg[2]));

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        pad_next    = pad_reg;
        pend80_next = pend80_reg;
        seen14_next = seen14_reg;
        done_next   = done_reg;
        dvalid_next = dvalid_reg;
        dword_next  = dword_reg;
        dindex_next = dindex_reg;
        dlast_next  = dlast_reg;
        chain_next  = chain_reg;
        var_next    = var_reg;
        push_en     = 1'b0;
        push_word   = 64'd0;
        shift_en    = 1'b0;
        shift_in    = sched_new;

        // A digest request leaves the output register when taken.
        if (dvalid_reg && !digest_stall)
        begin
            dvalid_next = 1'b0;
        end

        unique case (state_reg)
            sha512_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    push_en = 1'b1;
                    if (!end_of_message)
                    begin
                        push_word = message_word;
                        len_next  = len_reg + 64'd64;
                    end
                    else
                    begin
                        push_word   = (nb_clamp == sha512_pkg::FULL_BYTES) ? message_word
                                                                           : last_word;
                        len_next    = len_reg + {57'd0, nb_clamp, 3'b000};
                        pad_next    = 1'b1;
                        pend80_next = (nb_clamp == sha512_pkg::FULL_BYTES);
                        seen14_next = 1'b0;
                        done_next   = 1'b0;
                        state_next  = sha512_pkg::ST_PAD;
                    end
                end
            end
            sha512_pkg::ST_PAD:
            begin
                push_en = 1'b1;
                if (pend80_reg)
                begin
                    push_word   = sha512_pkg::PAD_MARKER;
                    pend80_next = 1'b0;
                end
                else if (fill_reg == LenSlot && seen14_reg)
                begin
                    push_word = len_reg;
                    done_next = 1'b1;
                end
                else
                begin
                    push_word = 64'd0;
                    if (fill_reg == ZeroSlot)
                    begin
                        seen14_next = 1'b1;
                    end
                end
            end
            sha512_pkg::ST_ROUND:
            begin
                shift_en    = 1'b1;
                var_next[7] = var_reg[6];
                var_next[6] = var_reg[5];
                var_next[5] = var_reg[4];
                var_next[4] = var_reg[3] + t1;
                var_next[3] = var_reg[2];
                var_next[2] = var_reg[1];
                var_next[1] = var_reg[0];
                var_next[0] = t1 + t2;
                round_next  = round_reg + 1'b1;
                if (round_reg == LastRound)
                begin
                    round_next = '0;
                    state_next = sha512_pkg::ST_ADD;
                end
            end
            sha512_pkg::ST_ADD:
            begin
                for (int k = 0; k < sha512_pkg::DIGEST_WORDS; k++)
                begin
                    chain_next[k] = chain_reg[k] + var_reg[k];
                end
                if (done_reg)
                begin
                    idx_next   = '0;
                    state_next = sha512_pkg::ST_EMIT;
                end
                else if (pad_reg)
                begin
                    state_next = sha512_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha512_pkg::ST_IDLE;
                end
            end
            sha512_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    dvalid_next = 1'b1;
                    dword_next  = chain_reg[idx_reg];
                    dindex_next = idx_reg;
                    dlast_next  = (idx_reg == LastIdx);
                    idx_next    = idx_reg + 1'b1;
                    if (idx_reg == LastIdx)
                    begin
                        chain_next = sha512_pkg::INIT_HASH;
                        len_next   = '0;
                        fill_next  = '0;
                        pad_next   = 1'b0;
                        done_next  = 1'b0;
                        state_next = sha512_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha512_pkg::ST_IDLE;
            end
        endcase

        // A word entering the block buffer; a full buffer starts the rounds.
        if (push_en)
        begin
            shift_en  = 1'b1;
            shift_in  = push_word;
            fill_next = fill_reg + 1'b1;
            if (fill_reg == LenSlot)
            begin
                var_next   = chain_reg;
                round_next = '0;
                state_next = sha512_pkg::ST_ROUND;
            end
        end

        // The window shifts one place toward slot zero.
        win_next = win_reg;
        if (shift_en)
        begin
            for (int i = 0; i < sha512_pkg::BLOCK_WORDS - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[sha512_pkg::BLOCK_WORDS - 1] = shift_in;
        end
    end

    // Control registers and chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha512_pkg::ST_IDLE;
            fill_reg   <= '0;
            round_reg  <= '0;
            idx_reg    <= '0;
            len_reg    <= '0;
            pad_reg    <= 1'b0;
            pend80_reg <= 1'b0;
            seen14_reg <= 1'b0;
            done_reg   <= 1'b0;
            dvalid_reg <= 1'b0;
            chain_reg  <= sha512_pkg::INIT_HASH;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            pad_reg    <= pad_next;
            pend80_reg <= pend80_next;
            seen14_reg <= seen14_next;
            done_reg   <= done_next;
            dvalid_reg <= dvalid_next;
            chain_reg  <= chain_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        var_reg    <= var_next;
        dword_reg  <= dword_next;
        dindex_reg <= dindex_next;
        dlast_reg  <= dlast_next;
    end

    assign message_stall = (state_reg != sha512_pkg::ST_IDLE);
    assign digest_valid  = dvalid_reg;
    assign digest_word   = dword_reg;
    assign digest_index  = dindex_reg;
    assign digest_last   = dlast_reg;

    // The round counter never passes the last round.
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= LastRound)
        else $error("round counter out of range");

    // The fold into the chaining value follows only the last round.
    a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha512_pkg::ST_ADD |->
            $past(state_reg == sha512_pkg::ST_ROUND && round_reg == LastRound))
        else $error("chaining add without a full round sequence");

    // Digest output starts only with an empty block buffer after the length word.
    a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha512_pkg::ST_EMIT |-> fill_reg == '0 && done_reg)
        else $error("digest output with a partly filled block");

    // Rounds always start from slot zero of a freshly filled block.
    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == sha512_pkg::ST_ROUND) |-> round_reg == '0 && fill_reg == '0)
        else $error("rounds started on a partial block");

endmodule
